/* rtl/core/tpd_pkg.sv */
// Shared types and constants of the trajectory point decimator.
`timescale 1ns / 1ps
package tpd_pkg;

  localparam int CFG_DIST_WIDTH  = 31;
  localparam int COS_WIDTH       = 16;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int SEC_WIDTH       = 32;
  localparam int NSEC_WIDTH      = 30;
  localparam int INDEX_WIDTH     = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int MUL_DIGIT       = 8;
  // cos is Q1.15, so cos^2 carries a scale of two to the thirtieth
  localparam int ANGLE_SHIFT     = 30;
  localparam int HIST_WIDTH      = 2;
  localparam int STEP_WIDTH      = 4;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_DISTANCE  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_DISTANCE  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COS_MAX_ANGLE = 2'd2;

  localparam logic [CFG_DIST_WIDTH-1:0] MAX_DIST_RESET = 31'd9830;
  localparam logic [CFG_DIST_WIDTH-1:0] MIN_DIST_RESET = 31'd6554;
  localparam logic [COS_WIDTH-1:0]      COS_RESET      = 16'hE9C6;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [HIST_WIDTH-1:0] HIST_EMPTY = 2'd0;
  localparam logic [HIST_WIDTH-1:0] HIST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_WAIT,
    ST_EMIT
  } state_t;

  typedef enum logic [STEP_WIDTH-1:0] {
    STP_MN2, STP_MX2,
    STP_DN0, STP_DN1, STP_DN2,
    STP_DO0, STP_DO1, STP_DO2,
    STP_PR0, STP_PR1, STP_PR2,
    STP_SQ, STP_C2, STP_RNA, STP_RNB
  } step_t;

  typedef enum logic [1:0] {
    V_NEXT,
    V_KEEP,
    V_DROP
  } verdict_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

/* rtl/core/tpd_fifo.sv */
// Short item queue between the accepting front and the decision back end.
`timescale 1ns / 1ps
module tpd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [WIDTH-1:0]      push_data,
  input  logic                  pop,
  output logic [WIDTH-1:0]      head,
  output tpd_pkg::queue_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head         = mem[rptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == (AW+1)'(DEPTH));

endmodule

/* rtl/core/tpd_mul.sv */
// Shared iterative multiplier: one digit of the second operand per cycle.
`timescale 1ns / 1ps
module tpd_mul #(
  parameter int WIDTH = 168
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic             done,
  output logic [WIDTH-1:0] product
);

  localparam int DIG = tpd_pkg::MUL_DIGIT;

  logic             busy;
  logic [WIDTH-1:0] asft;
  logic [WIDTH-1:0] bsft;
  logic [WIDTH-1:0] acc;
  logic [WIDTH+DIG-1:0] partial;

  assign partial = asft * bsft[DIG-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      asft <= a;
      bsft <= b;
      acc  <= '0;
    end else if (busy && !done) begin
      acc  <= acc + partial[WIDTH-1:0];
      asft <= asft << DIG;
      bsft <= bsft >> DIG;
    end
  end

  // finished once no digits of the multiplier remain
  assign done    = busy && (bsft == '0);
  assign product = acc;

endmodule

/* rtl/core/tpd_back.sv */
// Back end: distance and turn tests on queued samples, history and result register.
`timescale 1ns / 1ps
module tpd_back #(
  parameter int POS_WIDTH  = 32,
  parameter int QUAT_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [1+3*POS_WIDTH+4*QUAT_WIDTH+tpd_pkg::SEC_WIDTH+tpd_pkg::NSEC_WIDTH-1:0] head,
  input  tpd_pkg::queue_status_t                 status,
  output logic                                   pop,
  input  logic [tpd_pkg::CFG_DIST_WIDTH-1:0]     max_distance,
  input  logic [tpd_pkg::CFG_DIST_WIDTH-1:0]     min_distance,
  input  logic [tpd_pkg::COS_WIDTH-1:0]          cos_max_angle,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [tpd_pkg::INDEX_WIDTH-1:0]        point_index,
  output logic signed [POS_WIDTH-1:0]            kept_x,
  output logic signed [POS_WIDTH-1:0]            kept_y,
  output logic signed [POS_WIDTH-1:0]            kept_z,
  output logic signed [QUAT_WIDTH-1:0]           kept_qx,
  output logic signed [QUAT_WIDTH-1:0]           kept_qy,
  output logic signed [QUAT_WIDTH-1:0]           kept_qz,
  output logic signed [QUAT_WIDTH-1:0]           kept_qw,
  output logic signed [tpd_pkg::SEC_WIDTH-1:0]   kept_sec,
  output logic [tpd_pkg::NSEC_WIDTH-1:0]         kept_nsec
);

  localparam int P  = POS_WIDTH;
  localparam int MW = 4 * POS_WIDTH + 40;

  // queue head fields
  logic                                 h_op;
  logic [P-1:0]                         h_x, h_y, h_z;
  logic [QUAT_WIDTH-1:0]                h_qx, h_qy, h_qz, h_qw;
  logic [tpd_pkg::SEC_WIDTH-1:0]        h_sec;
  logic [tpd_pkg::NSEC_WIDTH-1:0]       h_nsec;

  assign {h_op, h_x, h_y, h_z, h_qx, h_qy, h_qz, h_qw, h_sec, h_nsec} = head;

  tpd_pkg::state_t   state, state_next;
  tpd_pkg::step_t    step, step_next;
  tpd_pkg::verdict_t verdict;

  logic                                item_op;
  logic signed [P-1:0]                 cur [3];
  logic [QUAT_WIDTH-1:0]               item_qx, item_qy, item_qz, item_qw;
  logic [tpd_pkg::SEC_WIDTH-1:0]       item_sec;
  logic [tpd_pkg::NSEC_WIDTH-1:0]      item_nsec;

  logic signed [P-1:0]                 newest [3];
  logic signed [P-1:0]                 older [3];
  logic [tpd_pkg::HIST_WIDTH-1:0]      hist;
  logic [tpd_pkg::INDEX_WIDTH-1:0]     kcount;

  logic signed [P:0]                   dn_v [3];
  logic signed [P:0]                   do_v [3];
  logic [P:0]                          dn_mag [3];
  logic [P:0]                          do_mag [3];
  logic                                dn_neg [3];
  logic                                do_neg [3];

  logic [MW-1:0] mn2, mx2, na, nb, pos_acc, neg_acc, dmag, sq, rr;
  logic          dneg;

  logic [MW-1:0] nb_sum, na_sum, pos_sum, neg_sum, lhs;
  logic          dneg_v;
  logic          lane_neg;
  logic [1:0]    lane;
  logic          c_neg;
  logic [tpd_pkg::COS_WIDTH-1:0] cmag;

  logic          mul_start;
  logic          mul_done;
  logic [MW-1:0] mul_a, mul_b, product;
  logic          out_free;
  logic          emit;

  assign c_neg    = cos_max_angle[tpd_pkg::COS_WIDTH-1];
  assign cmag     = c_neg ? tpd_pkg::COS_WIDTH'(-cos_max_angle) : cos_max_angle;
  assign out_free = !out_valid || !out_stall;

  tpd_mul #(.WIDTH(MW)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (product)
  );

  // segment differences against the history
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dn_v[i] = {cur[i][P-1], cur[i]} - {newest[i][P-1], newest[i]};
      do_v[i] = {newest[i][P-1], newest[i]} - {older[i][P-1], older[i]};
    end
  end

  always_comb begin
    case (step)
      tpd_pkg::STP_DN1, tpd_pkg::STP_DO1, tpd_pkg::STP_PR1: lane = 2'd1;
      tpd_pkg::STP_DN2, tpd_pkg::STP_DO2, tpd_pkg::STP_PR2: lane = 2'd2;
      default:                                              lane = 2'd0;
    endcase
  end

  always_comb begin
    case (step)
      tpd_pkg::STP_MN2: begin
        mul_a = MW'(min_distance);
        mul_b = MW'(min_distance);
      end
      tpd_pkg::STP_MX2: begin
        mul_a = MW'(max_distance);
        mul_b = MW'(max_distance);
      end
      tpd_pkg::STP_DN0, tpd_pkg::STP_DN1, tpd_pkg::STP_DN2: begin
        mul_a = MW'(dn_mag[lane]);
        mul_b = MW'(dn_mag[lane]);
      end
      tpd_pkg::STP_DO0, tpd_pkg::STP_DO1, tpd_pkg::STP_DO2: begin
        mul_a = MW'(do_mag[lane]);
        mul_b = MW'(do_mag[lane]);
      end
      tpd_pkg::STP_PR0, tpd_pkg::STP_PR1, tpd_pkg::STP_PR2: begin
        mul_a = MW'(do_mag[lane]);
        mul_b = MW'(dn_mag[lane]);
      end
      tpd_pkg::STP_SQ: begin
        mul_a = dmag;
        mul_b = dmag;
      end
      tpd_pkg::STP_C2: begin
        mul_a = MW'(cmag);
        mul_b = MW'(cmag);
      end
      tpd_pkg::STP_RNA: begin
        mul_a = na;
        mul_b = rr;
      end
      default: begin
        mul_a = rr;
        mul_b = nb;
      end
    endcase
  end

  // decide after each product
  always_comb begin
    nb_sum    = nb + product;
    na_sum    = na + product;
    lane_neg  = do_neg[lane] ^ dn_neg[lane];
    pos_sum   = lane_neg ? pos_acc : pos_acc + product;
    neg_sum   = lane_neg ? neg_acc + product : neg_acc;
    dneg_v    = neg_sum > pos_sum;
    lhs       = sq << tpd_pkg::ANGLE_SHIFT;
    verdict   = tpd_pkg::V_NEXT;
    step_next = tpd_pkg::step_t'(step + 4'd1);
    case (step)
      tpd_pkg::STP_DN2: begin
        if (nb_sum >= mx2) begin
          verdict = tpd_pkg::V_KEEP;
        end else if (nb_sum > mn2) begin
          verdict = (hist != tpd_pkg::HIST_FULL) ? tpd_pkg::V_KEEP : tpd_pkg::V_NEXT;
        end else begin
          verdict = tpd_pkg::V_DROP;
        end
      end
      tpd_pkg::STP_DO2: begin
        // zero-length segment counts as a right angle
        if (na_sum == '0 || nb == '0) begin
          verdict = c_neg ? tpd_pkg::V_KEEP : tpd_pkg::V_DROP;
        end
      end
      tpd_pkg::STP_PR2: begin
        if (!dneg_v && c_neg) begin
          verdict = tpd_pkg::V_KEEP;
        end else if (dneg_v && !c_neg) begin
          verdict = tpd_pkg::V_DROP;
        end
      end
      tpd_pkg::STP_RNB: begin
        verdict = (dneg ? (lhs < product) : (lhs > product)) ? tpd_pkg::V_KEEP
                                                             : tpd_pkg::V_DROP;
      end
      default: verdict = tpd_pkg::V_NEXT;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      tpd_pkg::ST_IDLE: begin
        if (!status.empty) state_next = tpd_pkg::ST_PREP;
      end
      tpd_pkg::ST_PREP: begin
        if (item_op == tpd_pkg::OP_CLEAR) begin
          state_next = tpd_pkg::ST_IDLE;
        end else if (hist == tpd_pkg::HIST_EMPTY) begin
          state_next = tpd_pkg::ST_EMIT;
        end else begin
          state_next = tpd_pkg::ST_MUL;
        end
      end
      tpd_pkg::ST_MUL: state_next = tpd_pkg::ST_WAIT;
      tpd_pkg::ST_WAIT: begin
        if (mul_done) begin
          case (verdict)
            tpd_pkg::V_KEEP: state_next = tpd_pkg::ST_EMIT;
            tpd_pkg::V_DROP: state_next = tpd_pkg::ST_IDLE;
            default:         state_next = tpd_pkg::ST_MUL;
          endcase
        end
      end
      tpd_pkg::ST_EMIT: begin
        if (out_free) state_next = tpd_pkg::ST_IDLE;
      end
      default: state_next = tpd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state == tpd_pkg::ST_IDLE) && !status.empty;
    mul_start = (state == tpd_pkg::ST_MUL);
    emit      = (state == tpd_pkg::ST_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tpd_pkg::ST_IDLE;
      step      <= tpd_pkg::STP_MN2;
      hist      <= tpd_pkg::HIST_EMPTY;
      kcount    <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        newest[i] <= '0;
        older[i]  <= '0;
      end
    end else begin
      state <= state_next;
      if (state == tpd_pkg::ST_PREP) begin
        step <= tpd_pkg::STP_MN2;
        if (item_op == tpd_pkg::OP_CLEAR) begin
          hist   <= tpd_pkg::HIST_EMPTY;
          kcount <= '0;
        end
      end else if (state == tpd_pkg::ST_WAIT && mul_done && verdict == tpd_pkg::V_NEXT) begin
        step <= step_next;
      end
      if (emit) begin
        out_valid <= 1'b1;
        if (kcount != '1) kcount <= kcount + 1'b1;
        if (hist != tpd_pkg::HIST_FULL) hist <= hist + 1'b1;
        for (int i = 0; i < 3; i++) begin
          older[i]  <= newest[i];
          newest[i] <= cur[i];
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk) begin
    if (pop) begin
      item_op   <= h_op;
      cur[0]    <= h_x;
      cur[1]    <= h_y;
      cur[2]    <= h_z;
      item_qx   <= h_qx;
      item_qy   <= h_qy;
      item_qz   <= h_qz;
      item_qw   <= h_qw;
      item_sec  <= h_sec;
      item_nsec <= h_nsec;
    end
    if (state == tpd_pkg::ST_PREP) begin
      na      <= '0;
      nb      <= '0;
      pos_acc <= '0;
      neg_acc <= '0;
      for (int i = 0; i < 3; i++) begin
        dn_neg[i] <= dn_v[i][P];
        do_neg[i] <= do_v[i][P];
        dn_mag[i] <= dn_v[i][P] ? (P+1)'(-dn_v[i]) : dn_v[i];
        do_mag[i] <= do_v[i][P] ? (P+1)'(-do_v[i]) : do_v[i];
      end
    end
    if (state == tpd_pkg::ST_WAIT && mul_done) begin
      case (step)
        tpd_pkg::STP_MN2: mn2 <= product;
        tpd_pkg::STP_MX2: mx2 <= product;
        tpd_pkg::STP_DN0, tpd_pkg::STP_DN1, tpd_pkg::STP_DN2: nb <= nb_sum;
        tpd_pkg::STP_DO0, tpd_pkg::STP_DO1, tpd_pkg::STP_DO2: na <= na_sum;
        tpd_pkg::STP_PR0, tpd_pkg::STP_PR1: begin
          pos_acc <= pos_sum;
          neg_acc <= neg_sum;
        end
        tpd_pkg::STP_PR2: begin
          dneg <= dneg_v;
          dmag <= dneg_v ? neg_sum - pos_sum : pos_sum - neg_sum;
        end
        tpd_pkg::STP_SQ:  sq <= product;
        tpd_pkg::STP_C2, tpd_pkg::STP_RNA: rr <= product;
        default: ;
      endcase
    end
    if (emit) begin
      point_index <= kcount;
      kept_x      <= cur[0];
      kept_y      <= cur[1];
      kept_z      <= cur[2];
      kept_qx     <= item_qx;
      kept_qy     <= item_qy;
      kept_qz     <= item_qz;
      kept_qw     <= item_qw;
      kept_sec    <= item_sec;
      kept_nsec   <= item_nsec;
    end
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty) else $error("pop from empty queue");
  a_hist_range: assert property (@(posedge clk) disable iff (rst)
    hist <= tpd_pkg::HIST_FULL) else $error("history count overflow");
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid) else $error("kept point not presented");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == tpd_pkg::ST_WAIT) else $error("product outside wait");
  a_index_sat: assert property (@(posedge clk) disable iff (rst)
    (emit && kcount == '1) |=> kcount == '1) else $error("index wrapped");
`endif

endmodule

/* rtl/core/trajectory_point_decimator.sv */
// Top level of the trajectory point decimator: input queue, config registers, back end.
`timescale 1ns / 1ps
// Keeps the pose samples worth recording as waypoints and emits each with its running
// index. Items enter a two-entry queue, so the input side keeps taking transfers, until
// both entries are filled, while the back end works and a result waits in the output
// register. A clear passes the back end through its idle and prepare states only, and
// the first sample after a clear or reset goes from prepare straight to emit. Every other
// sample runs a chain of multiplies on one shared multiplier that consumes eight bits of
// its second operand per cycle; a multiply ends once no significant byte of that operand
// remains. The distance test squares both distance limits and the new segment; the turn
// test adds the old segment, the dot product and a final comparison of squares.
// Configuration is always ready and is to be written only while the block is idle.
module trajectory_point_decimator #(
  parameter int POS_WIDTH  = 32,
  parameter int QUAT_WIDTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    operation,
  input  logic signed [POS_WIDTH-1:0]             pos_x,
  input  logic signed [POS_WIDTH-1:0]             pos_y,
  input  logic signed [POS_WIDTH-1:0]             pos_z,
  input  logic signed [QUAT_WIDTH-1:0]            quat_x,
  input  logic signed [QUAT_WIDTH-1:0]            quat_y,
  input  logic signed [QUAT_WIDTH-1:0]            quat_z,
  input  logic signed [QUAT_WIDTH-1:0]            quat_w,
  input  logic signed [tpd_pkg::SEC_WIDTH-1:0]    stamp_sec,
  input  logic [tpd_pkg::NSEC_WIDTH-1:0]          stamp_nsec,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [tpd_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [tpd_pkg::CFG_DATA_WIDTH-1:0]      cfg_data,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [tpd_pkg::INDEX_WIDTH-1:0]         point_index,
  output logic signed [POS_WIDTH-1:0]             kept_x,
  output logic signed [POS_WIDTH-1:0]             kept_y,
  output logic signed [POS_WIDTH-1:0]             kept_z,
  output logic signed [QUAT_WIDTH-1:0]            kept_qx,
  output logic signed [QUAT_WIDTH-1:0]            kept_qy,
  output logic signed [QUAT_WIDTH-1:0]            kept_qz,
  output logic signed [QUAT_WIDTH-1:0]            kept_qw,
  output logic signed [tpd_pkg::SEC_WIDTH-1:0]    kept_sec,
  output logic [tpd_pkg::NSEC_WIDTH-1:0]          kept_nsec
);

  localparam int EW = 1 + 3 * POS_WIDTH + 4 * QUAT_WIDTH
                    + tpd_pkg::SEC_WIDTH + tpd_pkg::NSEC_WIDTH;

  logic [tpd_pkg::CFG_DIST_WIDTH-1:0] max_distance;
  logic [tpd_pkg::CFG_DIST_WIDTH-1:0] min_distance;
  logic [tpd_pkg::COS_WIDTH-1:0]      cos_max_angle;

  logic                   push;
  logic                   pop;
  logic [EW-1:0]          entry;
  logic [EW-1:0]          head;
  tpd_pkg::queue_status_t status;

  assign cfg_ready = 1'b1;
  assign in_stall  = status.full;
  assign push      = in_valid && !in_stall;
  assign entry     = {operation, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w,
                      stamp_sec, stamp_nsec};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance  <= tpd_pkg::MAX_DIST_RESET;
      min_distance  <= tpd_pkg::MIN_DIST_RESET;
      cos_max_angle <= tpd_pkg::COS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tpd_pkg::CFG_MAX_DISTANCE:  max_distance  <= cfg_data[tpd_pkg::CFG_DIST_WIDTH-1:0];
        tpd_pkg::CFG_MIN_DISTANCE:  min_distance  <= cfg_data[tpd_pkg::CFG_DIST_WIDTH-1:0];
        tpd_pkg::CFG_COS_MAX_ANGLE: cos_max_angle <= cfg_data[tpd_pkg::COS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  tpd_fifo #(
    .WIDTH (EW),
    .DEPTH (tpd_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (entry),
    .pop       (pop),
    .head      (head),
    .status    (status)
  );

  tpd_back #(
    .POS_WIDTH  (POS_WIDTH),
    .QUAT_WIDTH (QUAT_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .status        (status),
    .pop           (pop),
    .max_distance  (max_distance),
    .min_distance  (min_distance),
    .cos_max_angle (cos_max_angle),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .point_index   (point_index),
    .kept_x        (kept_x),
    .kept_y        (kept_y),
    .kept_z        (kept_z),
    .kept_qx       (kept_qx),
    .kept_qy       (kept_qy),
    .kept_qz       (kept_qz),
    .kept_qw       (kept_qw),
    .kept_sec      (kept_sec),
    .kept_nsec     (kept_nsec)
  );

endmodule
